FILE: hw/rtl/brle_pkg.sv
// Shared types and constants for the bit run-length encoder.
`default_nettype none

package brle_pkg;

  localparam int LEN_W = 16;
  localparam int MAX_RESULTS = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEN_W-1:0] LENGTH_CAP = 16'd65535;
  localparam logic [LEN_W-1:0] RUN_BUDGET_RESET = 16'd65535;

  // One result beat.
  typedef struct packed {
    logic [LEN_W-1:0] run_bits;
    logic             run_value;
    logic             first_value;
    logic [LEN_W-1:0] run_number;
    logic             status;
    logic             final_item;
  } res_t;

  // Results produced by one input beat, in order, written into the queue.
  typedef struct packed {
    logic [1:0]                  cnt;
    res_t [MAX_RESULTS-1:0]      item;
  } push_t;

endpackage

`default_nettype wire

FILE: hw/rtl/brle_core.sv
// Encoder state and per-bit result generation.
`default_nettype none

module brle_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [brle_pkg::LEN_W-1:0]   cfg_data,
  input  wire logic                         fire,
  input  wire logic                         bit_in,
  input  wire logic                         start_of_set,
  input  wire logic                         end_of_set,
  output brle_pkg::push_t                   push
);

  logic [brle_pkg::LEN_W-1:0] run_budget;
  logic                       cur_value;
  logic                       cur_value_next;
  logic [brle_pkg::LEN_W-1:0] run_len;
  logic [brle_pkg::LEN_W-1:0] run_len_next;
  logic [brle_pkg::LEN_W-1:0] runs;
  logic [brle_pkg::LEN_W-1:0] runs_next;
  logic                       set_open;
  logic                       set_open_next;
  logic                       lead_bit;
  logic                       lead_bit_next;

  logic [brle_pkg::LEN_W-1:0] base;
  logic [brle_pkg::LEN_W-1:0] cand_len [brle_pkg::MAX_RESULTS];
  logic                       cand_val [brle_pkg::MAX_RESULTS];
  logic                       cand_fin [brle_pkg::MAX_RESULTS];
  logic [1:0]                 cand_n;
  logic [1:0]                 ok_cnt;
  logic                       ovf;
  logic                       alive;
  logic [brle_pkg::LEN_W:0]   idx;

  always_comb begin
    base           = start_of_set ? '0 : runs;
    lead_bit_next  = start_of_set ? bit_in : lead_bit;
    cur_value_next = cur_value;
    run_len_next   = run_len;
    cand_n         = 2'd0;
    for (int i = 0; i < brle_pkg::MAX_RESULTS; i++) begin
      cand_len[i] = '0;
      cand_val[i] = 1'b0;
      cand_fin[i] = 1'b0;
    end

    if (start_of_set) begin
      cur_value_next = bit_in;
      run_len_next   = brle_pkg::LEN_W'(1);
      if (end_of_set) begin
        cand_len[0] = brle_pkg::LEN_W'(1);
        cand_val[0] = bit_in;
        cand_fin[0] = 1'b1;
        cand_n      = 2'd1;
      end
    end else if (set_open) begin
      if (bit_in == cur_value) begin
        if (run_len >= brle_pkg::LENGTH_CAP) begin
          // A full-length run is closed and followed by an empty run of the
          // other value, so the alternation of run values stays intact.
          cand_len[0]  = run_len;
          cand_val[0]  = cur_value;
          cand_len[1]  = '0;
          cand_val[1]  = ~cur_value;
          cand_n       = 2'd2;
          run_len_next = brle_pkg::LEN_W'(1);
          if (end_of_set) begin
            cand_len[2] = brle_pkg::LEN_W'(1);
            cand_val[2] = cur_value;
            cand_fin[2] = 1'b1;
            cand_n      = 2'd3;
          end
        end else begin
          run_len_next = run_len + brle_pkg::LEN_W'(1);
          if (end_of_set) begin
            cand_len[0] = run_len + brle_pkg::LEN_W'(1);
            cand_val[0] = cur_value;
            cand_fin[0] = 1'b1;
            cand_n      = 2'd1;
          end
        end
      end else begin
        cand_len[0]    = run_len;
        cand_val[0]    = cur_value;
        cand_n         = 2'd1;
        cur_value_next = bit_in;
        run_len_next   = brle_pkg::LEN_W'(1);
        if (end_of_set) begin
          cand_len[1] = brle_pkg::LEN_W'(1);
          cand_val[1] = bit_in;
          cand_fin[1] = 1'b1;
          cand_n      = 2'd2;
        end
      end
    end

    // Emit candidates in order; the first one past the budget becomes the
    // overflow status beat and ends the set.
    push.cnt = 2'd0;
    ok_cnt   = 2'd0;
    ovf      = 1'b0;
    alive    = 1'b1;
    idx      = '0;
    for (int i = 0; i < brle_pkg::MAX_RESULTS; i++) begin
      idx = {1'b0, base} + (brle_pkg::LEN_W + 1)'(i);
      push.item[i].first_value = lead_bit_next;
      push.item[i].run_number  = idx[brle_pkg::LEN_W-1:0];
      if (idx < {1'b0, run_budget}) begin
        push.item[i].run_bits   = cand_len[i];
        push.item[i].run_value  = cand_val[i];
        push.item[i].status     = 1'b0;
        push.item[i].final_item = cand_fin[i];
      end else begin
        push.item[i].run_bits   = '0;
        push.item[i].run_value  = 1'b0;
        push.item[i].status     = 1'b1;
        push.item[i].final_item = 1'b1;
      end
      if (alive && (2'(i) < cand_n)) begin
        push.cnt = push.cnt + 2'd1;
        if (idx < {1'b0, run_budget}) begin
          ok_cnt = ok_cnt + 2'd1;
        end else begin
          ovf   = 1'b1;
          alive = 1'b0;
        end
      end
    end
    if (!fire) begin
      push.cnt = 2'd0;
    end

    runs_next     = base + brle_pkg::LEN_W'(ok_cnt);
    set_open_next = (start_of_set || set_open) ? !(ovf || end_of_set) : set_open;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_budget <= brle_pkg::RUN_BUDGET_RESET;
      cur_value  <= 1'b0;
      run_len    <= '0;
      runs       <= '0;
      set_open   <= 1'b0;
      lead_bit   <= 1'b0;
    end else begin
      if (cfg_write) begin
        run_budget <= cfg_data;
      end
      if (fire) begin
        cur_value <= cur_value_next;
        run_len   <= run_len_next;
        runs      <= runs_next;
        set_open  <= set_open_next;
        lead_bit  <= lead_bit_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/brle_queue.sv
// Result queue: takes up to three results a cycle, hands out one a cycle while out_ready is high.
`default_nettype none

module brle_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire brle_pkg::push_t push,
  output logic                 room,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output brle_pkg::res_t       out_data
);

  brle_pkg::res_t                   mem [brle_pkg::QUEUE_DEPTH];
  logic [brle_pkg::PTR_W-1:0]       wr_ptr;
  logic [brle_pkg::PTR_W-1:0]       rd_ptr;
  logic [brle_pkg::CNT_W-1:0]       count;
  logic                             pop;

  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Space for a full set of results regardless of the output side.
  assign room      = (count <= brle_pkg::CNT_W'(brle_pkg::QUEUE_DEPTH - brle_pkg::MAX_RESULTS));

  always_ff @(posedge clk) begin
    for (int k = 0; k < brle_pkg::MAX_RESULTS; k++) begin
      if (2'(k) < push.cnt) begin
        mem[wr_ptr + brle_pkg::PTR_W'(k)] <= push.item[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + brle_pkg::PTR_W'(push.cnt);
      if (pop) begin
        rd_ptr <= rd_ptr + brle_pkg::PTR_W'(1);
      end
      count <= count + brle_pkg::CNT_W'(push.cnt) - brle_pkg::CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/bit_run_length_encoder.sv
// Top level of the bit run-length encoder.
// The encoder takes one bit per input beat, with a start mark on the first bit
// of a set and an end mark on its last bit, and gives one result beat per run
// of equal bits as that run closes. A new input beat is taken in every cycle as
// long as the four-entry result queue holds at most one result; results leave
// at one per cycle while out_ready is high, so the sustained rate is one input
// beat per cycle for bits that close at most one run, and otherwise the input
// is held while the queue drains (a single input beat can give up to three
// results when a full-length run, 65535 bits, closes together with the end of
// the set). A result is written into the queue at the edge that accepts its
// bit, so out_valid rises right after that edge and the result can leave in
// the cycle after at the earliest. The run budget register is written with
// cfg_write and cfg_data and should only change while the block is idle.
`default_nettype none

module bit_run_length_encoder (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [brle_pkg::LEN_W-1:0]   cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         bit_in,
  input  wire logic                         start_of_set,
  input  wire logic                         end_of_set,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [brle_pkg::LEN_W-1:0]        run_bits,
  output logic                              run_value,
  output logic                              first_value,
  output logic [brle_pkg::LEN_W-1:0]        run_number,
  output logic                              status,
  output logic                              final_item
);

  logic            in_fire;
  brle_pkg::push_t push;
  brle_pkg::res_t  out_data;

  // An input beat is taken only when the queue can absorb every result it
  // might produce.
  assign in_fire = in_valid && in_ready;

  brle_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .fire         (in_fire),
    .bit_in       (bit_in),
    .start_of_set (start_of_set),
    .end_of_set   (end_of_set),
    .push         (push)
  );

  brle_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign run_bits    = out_data.run_bits;
  assign run_value   = out_data.run_value;
  assign first_value = out_data.first_value;
  assign run_number  = out_data.run_number;
  assign status      = out_data.status;
  assign final_item  = out_data.final_item;

`ifndef SYNTH
  // Results are only produced by an accepted input beat.
  a_push_on_fire: assert property (@(posedge clk) disable iff (rst)
    !in_fire |-> (push.cnt == 2'd0))
    else $error("results pushed without an accepted input beat");

  // An overflow status beat always closes the set and carries no run.
  a_status_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (final_item && (run_bits == '0) && !run_value))
    else $error("overflow status beat malformed");

  // The empty run after a full-length run is never the last run of a set.
  a_empty_not_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !status && (run_bits == '0)) |-> !final_item)
    else $error("zero-length run marked final");

  // Reset leaves the queue empty and ready for input.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("queue not empty after reset");
`endif

endmodule

`default_nettype wire

FILE: dv/tb_bit_run_length_encoder.sv
// Self-checking testbench for the bit run-length encoder: directed cases and random bitsets.
module tb_bit_run_length_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles to let pass before waiting on owed results, so that the monitor
  // has noted the last accepted beat before the count is trusted.
  localparam int SETTLE_CYCLES = 8;

  // Tracks the encoder state for every accepted input beat and holds the
  // result beats that the encoder still owes, oldest first.
  class run_tracker;
    logic [brle_pkg::LEN_W-1:0] budget;
    logic                       cur_val;
    logic [brle_pkg::LEN_W-1:0] run_len;
    logic [brle_pkg::LEN_W-1:0] runs_done;
    logic                       set_open;
    logic                       lead_bit;
    brle_pkg::res_t             runs_due[$];
    int                         errors;

    function new();
      budget    = brle_pkg::RUN_BUDGET_RESET;
      cur_val   = 1'b0;
      run_len   = '0;
      runs_done = '0;
      set_open  = 1'b0;
      lead_bit  = 1'b0;
      errors    = 0;
    endfunction

    function void set_budget(logic [brle_pkg::LEN_W-1:0] value);
      budget = value;
    endfunction

    function int pending();
      return runs_due.size();
    endfunction

    // Queues one run, or the overflow status once the budget is spent.
    // Returns 0 when the set has been aborted.
    function bit close_run(logic [brle_pkg::LEN_W-1:0] len, logic val, logic fin);
      brle_pkg::res_t r;
      r.first_value = lead_bit;
      r.run_number  = runs_done;
      if (runs_done >= budget) begin
        r.run_bits   = '0;
        r.run_value  = 1'b0;
        r.status     = 1'b1;
        r.final_item = 1'b1;
        runs_due.push_back(r);
        set_open = 1'b0;
        return 1'b0;
      end
      r.run_bits   = len;
      r.run_value  = val;
      r.status     = 1'b0;
      r.final_item = fin;
      runs_due.push_back(r);
      runs_done = runs_done + 1'b1;
      return 1'b1;
    endfunction

    function void take_bit(logic b, logic s, logic e);
      if (s) begin
        set_open  = 1'b1;
        runs_done = '0;
        lead_bit  = b;
        cur_val   = b;
        run_len   = brle_pkg::LEN_W'(1);
      end else begin
        if (!set_open) return;
        if (b == cur_val) begin
          if (run_len >= brle_pkg::LENGTH_CAP) begin
            // A full-length run is split by a zero-length run of the other value.
            if (!close_run(run_len, cur_val, 1'b0)) return;
            if (!close_run('0, ~cur_val, 1'b0)) return;
            run_len = brle_pkg::LEN_W'(1);
          end else begin
            run_len = run_len + 1'b1;
          end
        end else begin
          if (!close_run(run_len, cur_val, 1'b0)) return;
          cur_val = b;
          run_len = brle_pkg::LEN_W'(1);
        end
      end
      if (e) begin
        if (close_run(run_len, cur_val, 1'b1)) set_open = 1'b0;
      end
    endfunction

    function void check_run(brle_pkg::res_t got);
      brle_pkg::res_t want;
      if (runs_due.size() == 0) begin
        $error("result beat with no run pending: run_bits %0d, status %0d",
               got.run_bits, got.status);
        errors++;
        return;
      end
      want = runs_due.pop_front();
      if (got.run_bits != want.run_bits) begin
        $error("run_bits: expected %0d, got %0d", want.run_bits, got.run_bits);
        errors++;
      end
      if (got.run_value != want.run_value) begin
        $error("run_value: expected %0d, got %0d", want.run_value, got.run_value);
        errors++;
      end
      if (got.first_value != want.first_value) begin
        $error("first_value: expected %0d, got %0d", want.first_value, got.first_value);
        errors++;
      end
      if (got.run_number != want.run_number) begin
        $error("run_number: expected %0d, got %0d", want.run_number, got.run_number);
        errors++;
      end
      if (got.status != want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.final_item != want.final_item) begin
        $error("final_item: expected %0d, got %0d", want.final_item, got.final_item);
        errors++;
      end
    endfunction
  endclass

  // All inputs start at known values; reset is high from time zero.
  logic                       clk          = 1'b0;
  logic                       rst          = 1'b1;
  logic                       cfg_write    = 1'b0;
  logic [brle_pkg::LEN_W-1:0] cfg_data     = '0;
  logic                       in_valid     = 1'b0;
  logic                       bit_in       = 1'b0;
  logic                       start_of_set = 1'b0;
  logic                       end_of_set   = 1'b0;
  logic                       out_ready    = 1'b0;
  logic                       in_ready;
  logic                       out_valid;
  logic [brle_pkg::LEN_W-1:0] run_bits;
  logic                       run_value;
  logic                       first_value;
  logic [brle_pkg::LEN_W-1:0] run_number;
  logic                       status;
  logic                       final_item;

  // Idling controls. The sender skips a cycle with probability tx_idle_pct
  // percent before each beat; the receiver drops ready with rx_stall_pct.
  // hold_left forces the receiver to hold off for that many cycles.
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_left    = 0;
  int bits_sent    = 0;

  run_tracker     book;
  brle_pkg::res_t seen_beat;

  bit_run_length_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .bit_in       (bit_in),
    .start_of_set (start_of_set),
    .end_of_set   (end_of_set),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .run_bits     (run_bits),
    .run_value    (run_value),
    .first_value  (first_value),
    .run_number   (run_number),
    .status       (status),
    .final_item   (final_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses a beat.
  initial begin
    #8ms;
    $display("simulation failed");
    $finish;
  end

  // Receiver. The long hold-off is counted here so that it runs on its own
  // while the sender keeps offering beats.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Monitor. Everything is sampled at the rising edge, before any of the
  // nonblocking updates of that edge land, so both channels see the values
  // that the handshake actually used. An input beat can never produce a
  // result in the same cycle, so noting inputs first is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) book.take_bit(bit_in, start_of_set, end_of_set);
      if (out_valid && out_ready) begin
        seen_beat.run_bits    = run_bits;
        seen_beat.run_value   = run_value;
        seen_beat.first_value = first_value;
        seen_beat.run_number  = run_number;
        seen_beat.status      = status;
        seen_beat.final_item  = final_item;
        book.check_run(seen_beat);
      end
    end
  end

  // Offers one beat and returns at the edge that accepts it. The caller is
  // always sitting on a rising edge, so valid gets exactly one assignment per
  // time step: either it stays high for back-to-back beats, or it drops for
  // an idle gap and comes back after the gap.
  task automatic offer_bit(logic b, logic s, logic e);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    bit_in       <= b;
    start_of_set <= s;
    end_of_set   <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops offering, lets the monitor catch up with the last accepted beat,
  // then waits for every owed result to come out.
  task automatic settle();
    in_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (book.pending() != 0) @(posedge clk);
  endtask

  // Budget writes happen only from a settled state.
  task automatic write_budget(logic [brle_pkg::LEN_W-1:0] value);
    settle();
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    book.set_budget(value);
  endtask

  // A bitset made of runs of one to four equal bits. Without the end mark it
  // stays open and is abandoned by whatever start comes next.
  task automatic send_bitset(int nbits, bit with_end);
    logic val;
    int   left;
    val  = 1'($urandom_range(1));
    left = $urandom_range(1, 4);
    for (int i = 0; i < nbits; i++) begin
      offer_bit(val, i == 0, with_end && (i == nbits - 1));
      left--;
      if (left == 0) begin
        val  = ~val;
        left = $urandom_range(1, 4);
      end
    end
    bits_sent += nbits;
  endtask

  // A random phase: mostly well-formed bitsets, with some open sets that get
  // abandoned, stray bits outside any set, and one-bit sets mixed in.
  task automatic random_phase(int tx, int rx, logic [brle_pkg::LEN_W-1:0] budget,
                              int target);
    int pick;
    write_budget(budget);
    tx_idle_pct  = tx;
    rx_stall_pct = rx;
    bits_sent    = 0;
    while (bits_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_bitset($urandom_range(1, 12), 1'b1);
      end else if (pick < 80) begin
        send_bitset($urandom_range(1, 6), 1'b0);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 3)) begin
          offer_bit(1'($urandom_range(1)), 1'b0, 1'($urandom_range(1)));
        end
      end else begin
        offer_bit(1'($urandom_range(1)), 1'b1, 1'b1);
        bits_sent++;
      end
    end
  endtask

  initial begin
    book = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, budget at its reset value.
    // Bits before any start mark are dropped, even one with an end mark.
    offer_bit(1'b1, 1'b0, 1'b0);
    offer_bit(1'b0, 1'b0, 1'b1);
    // One-bit sets of both values.
    offer_bit(1'b1, 1'b1, 1'b1);
    offer_bit(1'b0, 1'b1, 1'b1);
    // An ordinary set: runs of 2, 3 and 1.
    offer_bit(1'b0, 1'b1, 1'b0);
    offer_bit(1'b0, 1'b0, 1'b0);
    offer_bit(1'b1, 1'b0, 1'b0);
    offer_bit(1'b1, 1'b0, 1'b0);
    offer_bit(1'b1, 1'b0, 1'b0);
    offer_bit(1'b0, 1'b0, 1'b1);
    // A start mark inside an open set abandons it without any result.
    offer_bit(1'b1, 1'b1, 1'b0);
    offer_bit(1'b1, 1'b0, 1'b0);
    offer_bit(1'b0, 1'b1, 1'b0);
    offer_bit(1'b1, 1'b0, 1'b1);
    // Bits after the end of a set are dropped.
    offer_bit(1'b1, 1'b0, 1'b0);
    offer_bit(1'b0, 1'b0, 1'b1);

    // Zero budget: the first run to close aborts the set, and the rest of
    // it is dropped up to the next start.
    write_budget('0);
    offer_bit(1'b1, 1'b1, 1'b0);
    offer_bit(1'b0, 1'b0, 1'b0);
    offer_bit(1'b1, 1'b0, 1'b1);
    offer_bit(1'b1, 1'b1, 1'b1);

    // Budget of one: the first run goes out, the closing one aborts.
    write_budget(16'd1);
    offer_bit(1'b0, 1'b1, 1'b0);
    offer_bit(1'b1, 1'b0, 1'b0);
    offer_bit(1'b1, 1'b0, 1'b1);

    // Pressure: hold the receiver off while a set of alternating bits keeps
    // closing runs, so the result queue fills and the input stalls.
    write_budget(brle_pkg::RUN_BUDGET_RESET);
    hold_left = 60;
    for (int i = 0; i < 14; i++) offer_bit(i[0], i == 0, i == 13);
    // Then the sender waits for every owed result before going on.
    settle();

    random_phase(0, 0, brle_pkg::RUN_BUDGET_RESET, 35);
    random_phase(65, 0, 16'd3, 35);
    random_phase(0, 65, 16'd2, 35);
    random_phase(32, 32, 16'($urandom_range(1, 6)), 35);

    settle();
    if (book.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
